// ----- rtl/drrs_pkg.sv -----
package drrs_pkg;

  localparam int MAX_MSG_BYTES = 8192;
  localparam int POS_W = $clog2(MAX_MSG_BYTES + 1);
  localparam logic [15:0] DATA_LIMIT_RST = 16'd1024;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QFIXED,
    PH_RNAME,
    PH_RFIXED,
    PH_RDATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_DATA,
    KIND_DONE,
    KIND_ERR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_LABEL,
    ERR_OVERFLOW,
    ERR_TRUNC
  } err_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  section;
    logic [17:0] record_number;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [15:0] data_length;
    logic [7:0]  data_value;
    logic [15:0] store_offset;
    logic [13:0] consumed_length;
    logic [17:0] total_records;
    logic [1:0]  error_code;
    logic        last;
  } out_t;

  // All results caused by one message byte.
  typedef struct packed {
    logic two;
    out_t res0;
    out_t res1;
  } pair_t;

endpackage

// ----- rtl/drrs_front.sv -----
module drrs_front
  import drrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        q_full,
  output logic        q_wr,
  output pair_t       q_pair
);

  phase_t             phase_r, phase_nxt;
  logic [3:0]         hdr_r, hdr_nxt;
  logic [15:0]        qtot_r, qtot_nxt;
  logic [15:0]        ans_r, ans_nxt;
  logic [15:0]        auth_r, auth_nxt;
  logic [15:0]        add_r, add_nxt;
  logic [15:0]        qleft_r, qleft_nxt;
  logic [17:0]        cur_r, cur_nxt;
  logic [5:0]         lbl_r, lbl_nxt;
  logic [3:0]         fixed_r, fixed_nxt;
  logic [15:0]        htype_r, htype_nxt;
  logic [15:0]        hclass_r, hclass_nxt;
  logic [15:0]        hlen_r, hlen_nxt;
  logic [15:0]        dleft_r, dleft_nxt;
  logic [16:0]        store_r, store_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               ptr_r, ptr_nxt;
  logic [15:0]        limit_r, limit_nxt;

  logic               acc;
  logic [7:0]         b;
  logic               msg_end;
  out_t               res_c [2];
  logic [1:0]         res_cnt;
  logic               enter;
  logic [16:0]        off_c;

  function automatic out_t mk(input kind_t k, input logic [15:0] offset,
                              input logic [7:0] dval, input err_t err,
                              input logic [17:0] cur, input logic [15:0] ans,
                              input logic [15:0] auth, input logic [15:0] add,
                              input logic [15:0] ht, input logic [15:0] hc,
                              input logic [15:0] hl, input logic [POS_W-1:0] pos);
    out_t        r;
    logic        rec;
    logic [16:0] ans_auth;
    logic [1:0]  sec;
    r        = '0;
    rec      = (k == KIND_HDR) || (k == KIND_DATA);
    ans_auth = {1'b0, ans} + {1'b0, auth};
    if (cur < {2'b00, ans}) begin
      sec = 2'd0;
    end else if (cur < {1'b0, ans_auth}) begin
      sec = 2'd1;
    end else begin
      sec = 2'd2;
    end
    r.result_kind   = k;
    r.total_records = {2'b00, ans} + {2'b00, auth} + {2'b00, add};
    if (rec) begin
      r.section       = sec;
      r.record_number = cur;
      r.record_type   = ht;
      r.record_class  = hc;
      r.data_length   = hl;
      r.store_offset  = offset;
    end
    if (k == KIND_DATA) r.data_value = dval;
    if (k == KIND_DONE) r.consumed_length = 14'(pos);
    if (k == KIND_ERR) r.error_code = err;
    return r;
  endfunction

  assign acc      = in_valid && in_ready;
  assign in_ready = !q_full;
  assign b        = in_data.msg_byte;
  assign msg_end  = in_data.msg_end;

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    qtot_nxt   = qtot_r;
    ans_nxt    = ans_r;
    auth_nxt   = auth_r;
    add_nxt    = add_r;
    qleft_nxt  = qleft_r;
    cur_nxt    = cur_r;
    lbl_nxt    = lbl_r;
    fixed_nxt  = fixed_r;
    htype_nxt  = htype_r;
    hclass_nxt = hclass_r;
    hlen_nxt   = hlen_r;
    dleft_nxt  = dleft_r;
    store_nxt  = store_r;
    pos_nxt    = pos_r;
    ptr_nxt    = ptr_r;
    limit_nxt  = cfg_we ? cfg_wdata : limit_r;
    res_c[0]   = '0;
    res_c[1]   = '0;
    res_cnt    = 2'd0;
    enter      = 1'b0;
    off_c      = '0;

    if (acc && phase_r != PH_DONE && phase_r != PH_ERROR) begin
      if (pos_r >= POS_W'(MAX_MSG_BYTES)) begin
        res_c[0]  = mk(KIND_ERR, '0, '0, ERR_TRUNC, cur_nxt, ans_nxt, auth_nxt, add_nxt,
                       htype_nxt, hclass_nxt, hlen_nxt, pos_nxt);
        res_cnt   = 2'd1;
        phase_nxt = PH_ERROR;
      end else begin
        pos_nxt = pos_r + 1'b1;
        case (phase_r)
          PH_HEADER: begin
            case (hdr_r) inside
              4'd4, 4'd5:   qtot_nxt = {qtot_r[7:0], b};
              4'd6, 4'd7:   ans_nxt  = {ans_r[7:0], b};
              4'd8, 4'd9:   auth_nxt = {auth_r[7:0], b};
              4'd10, 4'd11: add_nxt  = {add_r[7:0], b};
              default: ;
            endcase
            hdr_nxt = hdr_r + 1'b1;
            if (hdr_r >= 4'd11) begin
              qleft_nxt = qtot_nxt;
              if (qtot_nxt != '0) begin
                phase_nxt = PH_QNAME;
                lbl_nxt   = '0;
                ptr_nxt   = 1'b0;
              end else begin
                enter = 1'b1;
              end
            end
          end
          PH_QNAME, PH_RNAME: begin
            if (ptr_r) begin
              ptr_nxt   = 1'b0;
              fixed_nxt = '0;
              phase_nxt = (phase_r == PH_QNAME) ? PH_QFIXED : PH_RFIXED;
            end else if (lbl_r != '0) begin
              lbl_nxt = lbl_r - 1'b1;
            end else if (b == 8'd0) begin
              fixed_nxt = '0;
              phase_nxt = (phase_r == PH_QNAME) ? PH_QFIXED : PH_RFIXED;
            end else if (b[7:6] == 2'b11) begin
              ptr_nxt = 1'b1;
            end else if (b[7:6] == 2'b00) begin
              lbl_nxt = b[5:0];
            end else begin
              res_c[0]  = mk(KIND_ERR, '0, '0, ERR_LABEL, cur_nxt, ans_nxt, auth_nxt,
                             add_nxt, htype_nxt, hclass_nxt, hlen_nxt, pos_nxt);
              res_cnt   = 2'd1;
              phase_nxt = PH_ERROR;
            end
          end
          PH_QFIXED: begin
            fixed_nxt = fixed_r + 1'b1;
            if (fixed_r >= 4'd3) begin
              qleft_nxt = qleft_r - 1'b1;
              if (qleft_nxt != '0) begin
                phase_nxt = PH_QNAME;
                lbl_nxt   = '0;
                ptr_nxt   = 1'b0;
              end else begin
                enter = 1'b1;
              end
            end
          end
          PH_RFIXED: begin
            case (fixed_r) inside
              4'd0, 4'd1: htype_nxt  = {htype_r[7:0], b};
              4'd2, 4'd3: hclass_nxt = {hclass_r[7:0], b};
              4'd8, 4'd9: hlen_nxt   = {hlen_r[7:0], b};
              default: ;
            endcase
            fixed_nxt = fixed_r + 1'b1;
            if (fixed_r >= 4'd9) begin
              if ({1'b0, store_r} + {2'b00, hlen_nxt} > {2'b00, limit_r}) begin
                res_c[0]  = mk(KIND_ERR, '0, '0, ERR_OVERFLOW, cur_nxt, ans_nxt, auth_nxt,
                               add_nxt, htype_nxt, hclass_nxt, hlen_nxt, pos_nxt);
                res_cnt   = 2'd1;
                phase_nxt = PH_ERROR;
              end else begin
                res_c[0]  = mk(KIND_HDR, store_r[15:0], '0, ERR_NONE, cur_nxt, ans_nxt,
                               auth_nxt, add_nxt, htype_nxt, hclass_nxt, hlen_nxt, pos_nxt);
                res_cnt   = 2'd1;
                dleft_nxt = hlen_nxt;
                if (hlen_nxt == '0) begin
                  store_nxt = store_r + {1'b0, hlen_nxt} + 17'd1;
                  cur_nxt   = cur_r + 1'b1;
                  enter     = 1'b1;
                end else begin
                  phase_nxt = PH_RDATA;
                end
              end
            end
          end
          PH_RDATA: begin
            off_c     = store_r + {1'b0, hlen_r} - {1'b0, dleft_r};
            res_c[0]  = mk(KIND_DATA, off_c[15:0], b, ERR_NONE, cur_nxt, ans_nxt, auth_nxt,
                           add_nxt, htype_nxt, hclass_nxt, hlen_nxt, pos_nxt);
            res_cnt   = 2'd1;
            dleft_nxt = dleft_r - 1'b1;
            if (dleft_nxt == '0) begin
              store_nxt = store_r + {1'b0, hlen_r} + 17'd1;
              cur_nxt   = cur_r + 1'b1;
              enter     = 1'b1;
            end
          end
          default: ;
        endcase

        // Step into the record sections, or stop when none remain or the message ends.
        if (enter) begin
          if (cur_nxt >= ({2'b00, ans_nxt} + {2'b00, auth_nxt} + {2'b00, add_nxt})
              || msg_end) begin
            res_c[res_cnt[0]] = mk(KIND_DONE, '0, '0, ERR_NONE, cur_nxt, ans_nxt, auth_nxt,
                                   add_nxt, htype_nxt, hclass_nxt, hlen_nxt, pos_nxt);
            res_cnt   = res_cnt + 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_RNAME;
            lbl_nxt   = '0;
            ptr_nxt   = 1'b0;
          end
        end
      end

      if (msg_end && phase_nxt != PH_DONE && phase_nxt != PH_ERROR) begin
        res_c[res_cnt[0]] = mk(KIND_ERR, '0, '0, ERR_TRUNC, cur_nxt, ans_nxt, auth_nxt,
                               add_nxt, htype_nxt, hclass_nxt, hlen_nxt, pos_nxt);
        res_cnt   = res_cnt + 1'b1;
        phase_nxt = PH_ERROR;
      end
      if (res_cnt == 2'd2) begin
        res_c[1].last = 1'b1;
      end else begin
        res_c[0].last = 1'b1;
      end
    end

    // Rearm for the next message on its final byte.
    if (acc && msg_end) begin
      phase_nxt  = PH_HEADER;
      hdr_nxt    = '0;
      qtot_nxt   = '0;
      ans_nxt    = '0;
      auth_nxt   = '0;
      add_nxt    = '0;
      qleft_nxt  = '0;
      cur_nxt    = '0;
      lbl_nxt    = '0;
      fixed_nxt  = '0;
      htype_nxt  = '0;
      hclass_nxt = '0;
      hlen_nxt   = '0;
      dleft_nxt  = '0;
      store_nxt  = '0;
      pos_nxt    = '0;
      ptr_nxt    = 1'b0;
    end
  end

  assign q_wr        = acc && (res_cnt != 2'd0);
  assign q_pair.two  = (res_cnt == 2'd2);
  assign q_pair.res0 = res_c[0];
  assign q_pair.res1 = res_c[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hdr_r    <= '0;
      qtot_r   <= '0;
      ans_r    <= '0;
      auth_r   <= '0;
      add_r    <= '0;
      qleft_r  <= '0;
      cur_r    <= '0;
      lbl_r    <= '0;
      fixed_r  <= '0;
      htype_r  <= '0;
      hclass_r <= '0;
      hlen_r   <= '0;
      dleft_r  <= '0;
      store_r  <= '0;
      pos_r    <= '0;
      ptr_r    <= 1'b0;
      limit_r  <= DATA_LIMIT_RST;
    end else begin
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      qtot_r   <= qtot_nxt;
      ans_r    <= ans_nxt;
      auth_r   <= auth_nxt;
      add_r    <= add_nxt;
      qleft_r  <= qleft_nxt;
      cur_r    <= cur_nxt;
      lbl_r    <= lbl_nxt;
      fixed_r  <= fixed_nxt;
      htype_r  <= htype_nxt;
      hclass_r <= hclass_nxt;
      hlen_r   <= hlen_nxt;
      dleft_r  <= dleft_nxt;
      store_r  <= store_nxt;
      pos_r    <= pos_nxt;
      ptr_r    <= ptr_nxt;
      limit_r  <= limit_nxt;
    end
  end

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && msg_end) |=> (phase_r == PH_HEADER && pos_r == '0))
    else $error("parser not rearmed after final message byte");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> (q_pair.two ? (q_pair.res1.last && !q_pair.res0.last) : q_pair.res0.last))
    else $error("last flag not on final result of a byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_MSG_BYTES))
    else $error("byte position beyond message limit");

endmodule

// ----- rtl/drrs_queue.sv -----
module drrs_queue
  import drrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  pair_t wr_pair,
  output logic  full,
  input  logic  rd_en,
  output logic  not_empty,
  output pair_t rd_pair
);

  pair_t      mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_pair   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en)
    else $error("write into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> not_empty)
    else $error("read from empty queue");

endmodule

// ----- rtl/drrs_back.sv -----
module drrs_back
  import drrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_not_empty,
  input  pair_t q_pair,
  output logic  q_rd,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic sub_r, sub_nxt;
  logic take;

  assign out_valid = q_not_empty;
  assign out_data  = sub_r ? q_pair.res1 : q_pair.res0;
  assign take      = out_valid && out_ready;
  // Release the queue entry once its final result has gone out.
  assign q_rd      = take && (sub_r || !q_pair.two);

  always_comb begin
    sub_nxt = sub_r;
    if (take) begin
      sub_nxt = !q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

// ----- rtl/dns_response_record_scanner.sv -----
// DNS response record scanner.
// Input channel (in_valid/in_ready/in_data): one message byte per request,
// with msg_end marking the final byte of a message.
// Result channel (out_valid/out_ready/out_data): record headers, record data
// bytes, message done and error results, in message order; last marks the
// final result caused by one input byte.
// Configuration: cfg_we writes cfg_wdata into the data store limit (reset 1024)
// at that clock edge; write only while the block is idle.
// Results: a byte's results enter the queue when the byte is accepted. Throughput
// is one byte per cycle while each byte causes at most one result and out_ready
// stays high; a byte with two results holds its queue entry until both are taken.
// A two-entry queue between the parser and the result stage sets how far the
// input runs ahead; in_ready drops only when both entries are occupied.
// When the receiver stalls, the queue fills and in_ready falls; nothing is
// dropped. Reset clears the parser to the start of a message, empties the
// queue and restores the data limit. After done or error, bytes are absorbed
// without results up to and including the byte carrying msg_end.
module dns_response_record_scanner
  import drrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic  q_full;
  logic  q_wr;
  pair_t q_wr_pair;
  logic  q_rd;
  logic  q_not_empty;
  pair_t q_rd_pair;

  drrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_pair    (q_wr_pair)
  );

  drrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr),
    .wr_pair   (q_wr_pair),
    .full      (q_full),
    .rd_en     (q_rd),
    .not_empty (q_not_empty),
    .rd_pair   (q_rd_pair)
  );

  drrs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_pair      (q_rd_pair),
    .q_rd        (q_rd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import drrs_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 20;

  typedef enum int {
    MSG_WELL,
    MSG_CUT_ANY,
    MSG_CUT_EDGE,
    MSG_BAD_LABEL,
    MSG_TRAILING,
    MSG_NOISE
  } msg_form_t;

  typedef enum int {
    NAME_MORE,
    NAME_DONE,
    NAME_BAD
  } name_step_t;

  // Tracks the parser state and keeps the results each accepted byte must produce.
  class dns_scan_checker;
    int unsigned data_limit = DATA_LIMIT_RST;
    out_t        scan_results_due[$];
    int          failures;

    phase_t phase;
    int     hdr_seen, q_count, an_count, ns_count, ar_count, q_left, rec_idx;
    int     label_left, fixed_seen, rr_type, rr_class, rr_len, data_left;
    int     store_used, msg_pos;
    bit     ptr_pending;
    out_t   step_res[$];

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_HEADER;
      hdr_seen = 0; q_count = 0; an_count = 0; ns_count = 0; ar_count = 0;
      q_left = 0; rec_idx = 0; label_left = 0; fixed_seen = 0;
      rr_type = 0; rr_class = 0; rr_len = 0; data_left = 0;
      store_used = 0; msg_pos = 0; ptr_pending = 0;
    endfunction

    function int pending();
      return scan_results_due.size();
    endfunction

    function void emit(kind_t kind, int offset, int dval, err_t err);
      out_t       r;
      bit         rec;
      logic [1:0] sec;
      r = '0;
      rec = (kind == KIND_HDR) || (kind == KIND_DATA);
      if (rec_idx < an_count) sec = 2'd0;
      else if (rec_idx < an_count + ns_count) sec = 2'd1;
      else sec = 2'd2;
      r.result_kind = kind;
      if (rec) begin
        r.section       = sec;
        r.record_number = 18'(rec_idx);
        r.record_type   = 16'(rr_type);
        r.record_class  = 16'(rr_class);
        r.data_length   = 16'(rr_len);
        r.store_offset  = 16'(offset);
      end
      if (kind == KIND_DATA) r.data_value = 8'(dval);
      if (kind == KIND_DONE) r.consumed_length = 14'(msg_pos);
      if (kind == KIND_ERR) r.error_code = err;
      r.total_records = 18'(an_count + ns_count + ar_count);
      step_res.push_back(r);
    endfunction

    function void abort(err_t err);
      emit(KIND_ERR, 0, 0, err);
      phase = PH_ERROR;
    endfunction

    function void start_name(phase_t p);
      phase = p;
      label_left = 0;
      ptr_pending = 0;
    endfunction

    function void enter_records(bit fin);
      if (rec_idx >= an_count + ns_count + ar_count || fin) begin
        emit(KIND_DONE, 0, 0, ERR_NONE);
        phase = PH_DONE;
      end else begin
        start_name(PH_RNAME);
      end
    endfunction

    function name_step_t name_step(logic [7:0] b);
      if (ptr_pending) begin
        ptr_pending = 0;
        return NAME_DONE;
      end
      if (label_left != 0) begin
        label_left--;
        return NAME_MORE;
      end
      if (b == 8'h00) return NAME_DONE;
      if (b[7:6] == 2'b11) begin
        ptr_pending = 1;
        return NAME_MORE;
      end
      if (b[7:6] == 2'b00) begin
        label_left = b;
        return NAME_MORE;
      end
      return NAME_BAD;
    endfunction

    function void close_record(bit fin);
      store_used += rr_len + 1;
      rec_idx++;
      enter_records(fin);
    endfunction

    function void note_byte(in_t req);
      logic [7:0] b;
      bit         fin;
      name_step_t ns;
      out_t       t;
      b = req.msg_byte;
      fin = req.msg_end;
      step_res.delete();
      // Drop everything after done or error until the message ends.
      if (phase == PH_DONE || phase == PH_ERROR) begin
        if (fin) restart();
        return;
      end
      if (msg_pos >= MAX_MSG_BYTES) begin
        abort(ERR_TRUNC);
      end else begin
        msg_pos++;
        case (phase)
          PH_HEADER: begin
            case (hdr_seen)
              4, 5:    q_count  = ((q_count << 8) | b) & 16'hFFFF;
              6, 7:    an_count = ((an_count << 8) | b) & 16'hFFFF;
              8, 9:    ns_count = ((ns_count << 8) | b) & 16'hFFFF;
              10, 11:  ar_count = ((ar_count << 8) | b) & 16'hFFFF;
              default: ;
            endcase
            hdr_seen++;
            if (hdr_seen >= 12) begin
              q_left = q_count;
              if (q_left != 0) start_name(PH_QNAME);
              else enter_records(fin);
            end
          end
          PH_QNAME, PH_RNAME: begin
            ns = name_step(b);
            if (ns == NAME_BAD) begin
              abort(ERR_LABEL);
            end else if (ns == NAME_DONE) begin
              fixed_seen = 0;
              if (phase == PH_QNAME) phase = PH_QFIXED;
              else phase = PH_RFIXED;
            end
          end
          PH_QFIXED: begin
            fixed_seen++;
            if (fixed_seen >= 4) begin
              q_left = (q_left - 1) & 16'hFFFF;
              if (q_left != 0) start_name(PH_QNAME);
              else enter_records(fin);
            end
          end
          PH_RFIXED: begin
            case (fixed_seen)
              0, 1:    rr_type  = ((rr_type << 8) | b) & 16'hFFFF;
              2, 3:    rr_class = ((rr_class << 8) | b) & 16'hFFFF;
              8, 9:    rr_len   = ((rr_len << 8) | b) & 16'hFFFF;
              default: ;
            endcase
            fixed_seen++;
            if (fixed_seen >= 10) begin
              if (store_used + rr_len > data_limit) begin
                abort(ERR_OVERFLOW);
              end else begin
                emit(KIND_HDR, store_used, 0, ERR_NONE);
                data_left = rr_len;
                if (rr_len == 0) close_record(fin);
                else phase = PH_RDATA;
              end
            end
          end
          default: begin
            emit(KIND_DATA, store_used + rr_len - data_left, b, ERR_NONE);
            data_left = (data_left - 1) & 16'hFFFF;
            if (data_left == 0) close_record(fin);
          end
        endcase
      end
      if (fin && phase != PH_DONE && phase != PH_ERROR) abort(ERR_TRUNC);
      foreach (step_res[i]) begin
        t = step_res[i];
        t.last = (i == step_res.size() - 1);
        scan_results_due.push_back(t);
      end
      if (fin) restart();
    endfunction

    function void compare(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        failures++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (scan_results_due.size() == 0) begin
        $error("result_kind: expected no result, got %0d", got.result_kind);
        failures++;
        return;
      end
      want = scan_results_due.pop_front();
      compare("result_kind", want.result_kind, got.result_kind);
      compare("section", want.section, got.section);
      compare("record_number", want.record_number, got.record_number);
      compare("record_type", want.record_type, got.record_type);
      compare("record_class", want.record_class, got.record_class);
      compare("data_length", want.data_length, got.data_length);
      compare("data_value", want.data_value, got.data_value);
      compare("store_offset", want.store_offset, got.store_offset);
      compare("consumed_length", want.consumed_length, got.consumed_length);
      compare("total_records", want.total_records, got.total_records);
      compare("error_code", want.error_code, got.error_code);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  bit              calm = 1'b0;
  int              stall_cycles = 0;
  logic [7:0]      msg[$];
  int              cuts[$];
  dns_scan_checker scan = new();

  dns_response_record_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Keep register writes, requests and results in one ordered place.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) scan.data_limit = cfg_wdata;
      if (in_valid && in_ready) scan.note_byte(in_data);
      if (out_valid && out_ready) scan.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL dns_response_record_scanner");
      $finish;
    end
  end

  function automatic void put_u16(int v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endfunction

  function automatic void put_header(int qd, int an, int ns, int ar);
    put_u16($urandom);
    put_u16($urandom);
    put_u16(qd);
    put_u16(an);
    put_u16(ns);
    put_u16(ar);
    cuts.push_back(msg.size());
  endfunction

  function automatic void put_name(bit bad);
    int         labels, bad_pos, len;
    logic [1:0] top;
    labels = $urandom_range(0, 2);
    bad_pos = bad ? $urandom_range(0, labels) : -1;
    for (int i = 0; i <= labels; i++) begin
      if (i == bad_pos) begin
        // Top bits 01 or 10 are reserved.
        top = 2'($urandom_range(1, 2));
        msg.push_back({top, 6'($urandom)});
        return;
      end
      if (i == labels) break;
      len = $urandom_range(1, 4);
      msg.push_back(8'(len));
      repeat (len) msg.push_back(8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      msg.push_back({2'b11, 6'($urandom)});
      msg.push_back(8'($urandom));
    end else begin
      msg.push_back(8'h00);
    end
  endfunction

  function automatic void put_question(bit bad);
    put_name(bad);
    repeat (4) msg.push_back(8'($urandom));
    cuts.push_back(msg.size());
  endfunction

  function automatic void put_record(int len, int nbytes, bit bad);
    put_name(bad);
    put_u16($urandom);
    put_u16($urandom);
    repeat (4) msg.push_back(8'($urandom));
    put_u16(len);
    repeat (nbytes) msg.push_back(8'($urandom));
    cuts.push_back(msg.size());
  endfunction

  function automatic void truncate(int keep);
    while (msg.size() > keep) void'(msg.pop_back());
  endfunction

  function automatic void build_random();
    msg_form_t form;
    int        roll, qd, an, ns, ar, nrec, bad_at, len, keep;
    roll = $urandom_range(0, 99);
    if (roll < 55) form = MSG_WELL;
    else if (roll < 67) form = MSG_CUT_ANY;
    else if (roll < 77) form = MSG_CUT_EDGE;
    else if (roll < 85) form = MSG_BAD_LABEL;
    else if (roll < 93) form = MSG_TRAILING;
    else form = MSG_NOISE;
    msg.delete();
    cuts.delete();
    if (form == MSG_NOISE) begin
      repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom));
      return;
    end
    qd = $urandom_range(0, 2);
    an = $urandom_range(0, 2);
    ns = $urandom_range(0, 1);
    ar = $urandom_range(0, 1);
    if (form == MSG_BAD_LABEL && qd + an + ns + ar == 0) qd = 1;
    nrec = an + ns + ar;
    bad_at = (form == MSG_BAD_LABEL) ? $urandom_range(0, qd + nrec - 1) : -1;
    // Now and then announce more answers than the message carries.
    if ($urandom_range(0, 9) == 0) an = $urandom_range(3, 65535);
    put_header(qd, an, ns, ar);
    for (int i = 0; i < qd; i++) put_question(i == bad_at);
    for (int i = 0; i < nrec; i++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      put_record(len, len, (qd + i) == bad_at);
    end
    case (form)
      MSG_CUT_ANY:  keep = $urandom_range(1, msg.size());
      MSG_CUT_EDGE: keep = cuts[$urandom_range(0, cuts.size() - 1)];
      default:      keep = msg.size();
    endcase
    truncate(keep);
    if (form == MSG_TRAILING) repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
  endfunction

  task automatic send_byte(logic [7:0] b, bit fin);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{msg_byte: b, msg_end: fin};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    msg.delete();
    cuts.delete();
  endtask

  // Wait out every pending result plus bytes that may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scan.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] limits[6];
    int          sent;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Header only, no sections.
    put_header(0, 0, 0, 0);
    send_msg();
    // Largest counts, message ends right after the header.
    put_header(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_msg();
    // Longest label, every section, junk after done.
    put_header(2, 1, 1, 1);
    msg.push_back(8'd63);
    repeat (63) msg.push_back(8'($urandom));
    put_question(0);
    put_question(0);
    put_record(0, 0, 0);
    put_record(3, 3, 0);
    put_record(1, 1, 0);
    repeat (3) msg.push_back(8'($urandom));
    send_msg();
    // Reserved label bits 01 and 10.
    put_header(1, 0, 0, 0);
    msg.push_back(8'h40);
    msg.push_back(8'h00);
    send_msg();
    put_header(1, 1, 0, 0);
    msg.push_back(8'hBF);
    repeat (4) msg.push_back(8'($urandom));
    send_msg();
    // Truncated inside the header.
    repeat (5) msg.push_back(8'($urandom));
    send_msg();
    msg.push_back(8'($urandom));
    send_msg();
    // End on a data byte, then on the record header byte.
    put_header(0, 1, 0, 0);
    put_record(5, 5, 0);
    truncate(msg.size() - 2);
    send_msg();
    put_header(0, 2, 0, 0);
    put_record(4, 4, 0);
    truncate(cuts[$] - 4);
    send_msg();
    // End between records while records remain.
    put_header(1, 2, 0, 0);
    put_question(0);
    send_msg();
    put_header(0, 3, 0, 0);
    put_record(2, 2, 0);
    send_msg();

    // Empty store: a zero-length record fits once.
    write_limit(16'd0);
    put_header(0, 2, 0, 0);
    put_record(0, 0, 0);
    put_record(0, 0, 0);
    send_msg();
    // Fill the store exactly, then overflow by the terminator.
    write_limit(16'd10);
    put_header(0, 3, 0, 0);
    put_record(5, 5, 0);
    put_record(4, 4, 0);
    put_record(0, 0, 0);
    send_msg();
    // Full-size store: largest data length fits alone, not after another record.
    write_limit(16'hFFFF);
    put_header(0, 1, 0, 0);
    put_record(16'hFFFF, 5, 0);
    send_msg();
    put_header(0, 2, 0, 0);
    put_record(0, 0, 0);
    put_record(16'hFFFF, 3, 0);
    send_msg();

    limits[0] = DATA_LIMIT_RST;
    limits[1] = 16'd24;
    limits[2] = 16'($urandom);
    limits[3] = 16'd60;
    limits[4] = 16'hFFFF;
    limits[5] = 16'($urandom_range(0, 200));
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      calm <= (p == 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_random();
        sent += msg.size();
        send_msg();
      end
    end
    calm <= 1'b0;
    settle();

    if (scan.failures == 0 && scan.pending() == 0) begin
      $display("PASS dns_response_record_scanner");
    end else begin
      $display("FAIL dns_response_record_scanner");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/drrs_pkg.sv
rtl/drrs_front.sv
rtl/drrs_queue.sv
rtl/drrs_back.sv
rtl/dns_response_record_scanner.sv
tb/tb_top.sv
